/* rtl/cfgov_pkg.sv */
// ----------------------------------------------------------------------------
// cfgov_pkg
// types, codes and constants shared by the clock ceiling governor
// ----------------------------------------------------------------------------
package cfgov_pkg;

    localparam int CORE_COUNT = 2;
    localparam int CORE_W     = $clog2(CORE_COUNT + 1);
    localparam int DEN_W      = 64 + CORE_W;
    localparam int DSH_W      = DEN_W + 8;
    localparam int REM_W      = DSH_W;
    localparam int Q_STEPS    = 9;
    localparam int CNT_W      = $clog2(Q_STEPS);

    // now_us / 1000 in 22-bit chunks, each by reciprocal multiply
    localparam int DIV_STEPS  = 3;
    localparam int MS_CHUNK   = 22;
    localparam int MS_SRC_W   = DIV_STEPS * MS_CHUNK;
    localparam int MS_SHIFT   = 38;

    localparam logic [31:0] MS_RECIP = 32'd274877907;
    localparam logic [10:0] MS_DIV   = 11'd1000;
    localparam logic [6:0]  PCT_FULL = 7'd100;

    localparam logic [1:0] PH_AWAKE = 2'd0;
    localparam logic [1:0] PH_DIM   = 2'd1;
    localparam logic [1:0] PH_OFF   = 2'd2;

    localparam logic [2:0] DEMAND_LAST = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ACTIVITY = 2'd1,
        OP_DEMAND   = 2'd2,
        OP_PHASE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        R_FOREGROUND = 3'd0,
        R_RECENT     = 3'd1,
        R_BALANCED   = 3'd2,
        R_VIS_IDLE   = 3'd3,
        R_LOAD_GUARD = 3'd4,
        R_LONG_IDLE  = 3'd5,
        R_SCREEN_OFF = 3'd6,
        R_DIM        = 3'd7
    } t_reason;

    typedef enum logic [2:0] {
        CFG_BOOST_MHZ      = 3'd0,
        CFG_IDLE_MHZ       = 3'd1,
        CFG_LONG_IDLE_MHZ  = 3'd2,
        CFG_SCREEN_OFF_MHZ = 3'd3,
        CFG_BOOST_HOLD_MS  = 3'd4,
        CFG_LONG_IDLE_MS   = 3'd5,
        CFG_GUARD_ENTER    = 3'd6,
        CFG_GUARD_EXIT     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [63:0] now_us;
        logic [63:0] idle_total_us;
        logic [2:0]  demand_index;
        logic        demand_active;
        logic [1:0]  phase;
        logic [9:0]  floor_mhz;
    } t_in_item;

    typedef struct packed {
        logic [9:0] req_mhz;
        logic [9:0] set_mhz;
        logic       write_frequency;
        t_reason    reason_code;
        logic [6:0] load_pct;
        logic       guard_on;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic div_mul;
        logic div_sub;
        logic apply;
        logic diff;
        logic store_sample;
        logic scale;
        logic q_step;
        logic load_upd;
        logic cmp;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic no_change;
        logic skip_sample;
        logic emit;
    } t_status;

endpackage

/* rtl/cfgov_ctrl.sv */
// ----------------------------------------------------------------------------
// cfgov_ctrl
// sequencer: divide, apply event, sample load, evaluate and emit
// ----------------------------------------------------------------------------
module cfgov_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  cfgov_pkg::t_status i_status,
    output cfgov_pkg::t_cmd    o_cmd
);
    import cfgov_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DMUL  = 10'b0000000010,
        S_DSUB  = 10'b0000000100,
        S_APPLY = 10'b0000001000,
        S_DIFF  = 10'b0000010000,
        S_SCALE = 10'b0000100000,
        S_QDIV  = 10'b0001000000,
        S_LOAD  = 10'b0010000000,
        S_CMP   = 10'b0100000000,
        S_EVAL  = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_DMUL;
                end
            end
            S_DMUL: begin
                o_cmd.div_mul = 1'b1;
                n_state       = S_DSUB;
            end
            S_DSUB: begin
                o_cmd.div_sub = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_APPLY;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DMUL;
                end
            end
            S_APPLY: begin
                if (i_status.op == OP_TICK) begin
                    n_state = S_DIFF;
                end else if (i_status.no_change) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                if (i_status.skip_sample) begin
                    o_cmd.store_sample = 1'b1;
                    n_state            = S_CMP;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_cnt       = '0;
                n_state     = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.q_step = 1'b1;
                if (r_cnt == CNT_W'(Q_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.load_upd     = 1'b1;
                o_cmd.store_sample = 1'b1;
                n_state            = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                if (!i_status.emit) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/cfgov_dp.sv */
// ----------------------------------------------------------------------------
// cfgov_dp
// governor datapath: registers, ms divider, load divider, priority chain
// ----------------------------------------------------------------------------
module cfgov_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  cfgov_pkg::t_in_item  i_in,
    input  cfgov_pkg::t_cmd      i_cmd,
    output cfgov_pkg::t_status   o_status,
    output cfgov_pkg::t_out_item o_out
);
    import cfgov_pkg::*;

    // configuration
    logic [9:0]  r_boost_mhz, r_idle_mhz, r_long_idle_mhz, r_screen_off_mhz;
    logic [31:0] r_boost_hold_ms, r_long_idle_ms;
    logic [6:0]  r_guard_enter, r_guard_exit;

    // governor state
    logic [6:0]  r_demand_mask;
    logic [1:0]  r_phase;
    logic [63:0] r_last_act_ms;
    logic [63:0] r_last_sample_us;
    logic [63:0] r_last_idle_us;
    logic [6:0]  r_cpu_load;
    logic        r_guard;
    logic [9:0]  r_last_applied;
    logic [9:0]  r_prev_req;
    t_reason     r_prev_reason;
    logic        r_prev_valid;

    // working registers
    t_in_item            r_item;
    logic [MS_SRC_W-1:0] r_src;
    logic [63:0]         r_quo;
    logic [9:0]          r_mrem;
    logic [MS_CHUNK-1:0] r_qdig;
    logic [63:0]         r_elapsed;
    logic [63:0]         r_idiff;
    logic [REM_W-1:0]    r_rem;
    logic [DSH_W-1:0]    r_dsh;
    logic [8:0]          r_q;
    logic                r_lt_boost, r_lt_long;
    t_out_item           r_out;

    logic [31:0] div_dend, div_rem;
    logic [63:0] div_prod;
    logic [6:0]  demand_bit, mask_upd;
    logic        no_change;
    logic        skip_sample;
    logic        q_bit;
    logic [6:0]  idle_pct, load_new;
    logic [63:0] idle_ms;
    logic [9:0]  req, applied;
    t_reason     reason;
    logic        fchg, emit;

    // ms divider, one 22-bit chunk at a time: multiply, then subtract
    assign div_dend = {r_mrem, r_src[MS_SRC_W-1 -: MS_CHUNK]};
    assign div_prod = 64'(div_dend) * 64'(MS_RECIP);
    assign div_rem  = div_dend - 32'(r_qdig) * 32'(MS_DIV);

    assign demand_bit = 7'd1 << r_item.demand_index;
    assign mask_upd   = r_item.demand_active ? (r_demand_mask | demand_bit)
                                             : (r_demand_mask & ~demand_bit);

    always_comb begin
        case (r_item.op)
            OP_DEMAND: no_change = (r_item.demand_index > DEMAND_LAST) ||
                                   (mask_upd == r_demand_mask);
            OP_PHASE:  no_change = (r_item.phase == r_phase);
            default:   no_change = 1'b0;
        endcase
    end

    assign skip_sample = (r_last_sample_us == 64'd0) ||
                         (r_item.now_us <= r_last_sample_us) ||
                         (r_item.idle_total_us < r_last_idle_us);

    assign q_bit    = (r_rem >= REM_W'(r_dsh));
    assign idle_pct = (r_q > 9'(PCT_FULL)) ? PCT_FULL : r_q[6:0];
    assign load_new = PCT_FULL - idle_pct;

    assign idle_ms = r_quo - r_last_act_ms;

    // priority chain
    always_comb begin
        if (r_phase == PH_OFF) begin
            req = r_screen_off_mhz; reason = R_SCREEN_OFF;
        end else if (r_phase == PH_DIM) begin
            req = r_idle_mhz; reason = R_DIM;
        end else if (r_demand_mask[3:0] != 4'd0) begin
            req = r_boost_mhz; reason = R_FOREGROUND;
        end else if (r_lt_boost) begin
            req = r_boost_mhz; reason = R_RECENT;
        end else if (r_demand_mask[6:4] != 3'd0) begin
            req = r_idle_mhz; reason = R_BALANCED;
        end else if (r_lt_long) begin
            req = r_idle_mhz; reason = R_VIS_IDLE;
        end else if (r_guard) begin
            req = r_idle_mhz; reason = R_LOAD_GUARD;
        end else begin
            req = r_long_idle_mhz; reason = R_LONG_IDLE;
        end
    end

    assign applied = (req > r_item.floor_mhz) ? req : r_item.floor_mhz;
    assign fchg    = (applied != r_last_applied);
    assign emit    = !r_prev_valid || fchg || (req != r_prev_req) || (reason != r_prev_reason);

    assign o_status.op          = r_item.op;
    assign o_status.no_change   = no_change;
    assign o_status.skip_sample = skip_sample;
    assign o_status.emit        = emit;
    assign o_out                = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_mhz      <= 10'd240;
            r_idle_mhz       <= 10'd160;
            r_long_idle_mhz  <= 10'd80;
            r_screen_off_mhz <= 10'd40;
            r_boost_hold_ms  <= 32'd3000;
            r_long_idle_ms   <= 32'd30000;
            r_guard_enter    <= 7'd85;
            r_guard_exit     <= 7'd60;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BOOST_MHZ:      r_boost_mhz      <= i_cfg_data[9:0];
                CFG_IDLE_MHZ:       r_idle_mhz       <= i_cfg_data[9:0];
                CFG_LONG_IDLE_MHZ:  r_long_idle_mhz  <= i_cfg_data[9:0];
                CFG_SCREEN_OFF_MHZ: r_screen_off_mhz <= i_cfg_data[9:0];
                CFG_BOOST_HOLD_MS:  r_boost_hold_ms  <= i_cfg_data;
                CFG_LONG_IDLE_MS:   r_long_idle_ms   <= i_cfg_data;
                CFG_GUARD_ENTER:    r_guard_enter    <= i_cfg_data[6:0];
                CFG_GUARD_EXIT:     r_guard_exit     <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_demand_mask    <= '0;
            r_phase          <= PH_AWAKE;
            r_last_act_ms    <= '0;
            r_last_sample_us <= '0;
            r_last_idle_us   <= '0;
            r_cpu_load       <= '0;
            r_guard          <= 1'b0;
            r_last_applied   <= '0;
            r_prev_req       <= '0;
            r_prev_reason    <= R_FOREGROUND;
            r_prev_valid     <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                case (r_item.op)
                    OP_ACTIVITY: begin
                        r_last_act_ms <= r_quo;
                    end
                    OP_DEMAND: begin
                        r_demand_mask <= mask_upd;
                        r_last_act_ms <= r_quo;
                    end
                    OP_PHASE: begin
                        r_phase <= r_item.phase;
                        if (r_item.phase == PH_AWAKE) begin
                            r_last_act_ms <= r_quo;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.store_sample) begin
                r_last_sample_us <= r_item.now_us;
                r_last_idle_us   <= r_item.idle_total_us;
            end
            if (i_cmd.load_upd) begin
                r_cpu_load <= load_new;
                if (load_new >= r_guard_enter) begin
                    r_guard <= 1'b1;
                end else if (load_new <= r_guard_exit) begin
                    r_guard <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                if (fchg) begin
                    r_last_applied <= applied;
                end
                r_prev_req    <= req;
                r_prev_reason <= reason;
                r_prev_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in;
            r_src  <= MS_SRC_W'(i_in.now_us);
            r_quo  <= '0;
            r_mrem <= '0;
        end
        if (i_cmd.div_mul) begin
            r_qdig <= div_prod[MS_SHIFT +: MS_CHUNK];
        end
        if (i_cmd.div_sub) begin
            r_mrem <= div_rem[9:0];
            r_src  <= r_src << MS_CHUNK;
            r_quo  <= {r_quo[63-MS_CHUNK:0], r_qdig};
        end
        if (i_cmd.diff) begin
            r_elapsed <= r_item.now_us - r_last_sample_us;
            r_idiff   <= r_item.idle_total_us - r_last_idle_us;
        end
        if (i_cmd.scale) begin
            // idle * 100 and elapsed * cores, divisor aligned to quotient bit 8
            r_rem <= (REM_W'(r_idiff) << 6) + (REM_W'(r_idiff) << 5) + (REM_W'(r_idiff) << 2);
            r_dsh <= DSH_W'(DEN_W'(r_elapsed) * DEN_W'(CORE_COUNT)) << 8;
            r_q   <= '0;
        end
        if (i_cmd.q_step) begin
            if (q_bit) begin
                r_rem <= r_rem - REM_W'(r_dsh);
            end
            r_q   <= {r_q[7:0], q_bit};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.cmp) begin
            r_lt_boost <= (idle_ms < {32'd0, r_boost_hold_ms});
            r_lt_long  <= (idle_ms < {32'd0, r_long_idle_ms});
        end
        if (i_cmd.commit) begin
            r_out.req_mhz         <= req;
            r_out.set_mhz         <= applied;
            r_out.write_frequency <= fchg;
            r_out.reason_code     <= reason;
            r_out.load_pct        <= r_cpu_load;
            r_out.guard_on        <= r_guard;
        end
    end

endmodule

/* rtl/cpu_frequency_governor.sv */
// ----------------------------------------------------------------------------
// cpu_frequency_governor: clock ceiling governor, one item at a time
// accept: a new item is taken only in idle, once the last one is done; every
//   item waits for the divide of now_us by 1000, ticks that take a sample also
//   run the 9-step load divider, and an emitting item waits for a free output
// reset: synchronous, clears governor state; config returns to defaults
// ----------------------------------------------------------------------------
module cpu_frequency_governor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cfgov_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cfgov_pkg::t_out_item o_out
);
    import cfgov_pkg::*;

    t_cmd    cmd;
    t_status status;

    cfgov_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cfgov_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule
